// ----- hdl/lfg_pkg.sv -----
// ---------------------------------------------------------------------------
// lfg_pkg - shared types and constants for the LCM/GCD block
// Controller states, the command and status bundles between controller and
// datapath, and the fixed field widths of the ports.
// ---------------------------------------------------------------------------
`default_nettype none

package lfg_pkg;

    localparam int FIELD_WIDTH       = 32;
    localparam int RESULT_WIDTH      = 64;
    localparam int OPERAND_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL_INIT,
        ST_MUL,
        ST_DONE
    } lfg_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul_init;
        logic mul_step;
    } lfg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic gcd_done;
        logic zero_operand;
        logic count_last;
    } lfg_status_t;

endpackage

`default_nettype wire

// ----- hdl/lfg_datapath.sv -----
// ---------------------------------------------------------------------------
// lfg_datapath - operand, GCD, divider and multiplier registers
// Binary GCD one step per cycle, restoring division of the first operand by
// the GCD one bit per cycle, then shift-add multiply by the second operand.
// ---------------------------------------------------------------------------
`default_nettype none

module lfg_datapath #(
    parameter int OPERAND_WIDTH = lfg_pkg::OPERAND_WIDTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire lfg_pkg::lfg_cmd_t             cmd,
    input  wire [lfg_pkg::FIELD_WIDTH-1:0]     first_value,
    input  wire [lfg_pkg::FIELD_WIDTH-1:0]     second_value,
    output lfg_pkg::lfg_status_t               status,
    output logic [lfg_pkg::RESULT_WIDTH-1:0]   common_multiple,
    output logic [lfg_pkg::FIELD_WIDTH-1:0]    common_divisor
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]   opa_reg, opa_next;
    logic [W-1:0]   opb_reg, opb_next;
    logic [W-1:0]   ga_reg, ga_next;
    logic [W-1:0]   gb_reg, gb_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [W-1:0]   g_reg, g_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   quo_reg, quo_next;
    logic [2*W-1:0] prod_reg, prod_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic [W:0]     div_shift;
    logic [W:0]     div_diff;
    logic [W:0]     mul_sum;

    assign div_shift = {rem_reg, quo_reg[W-1]};
    assign div_diff  = div_shift - {1'b0, g_reg};
    assign mul_sum   = {1'b0, prod_reg[2*W-1:W]} + {1'b0, quo_reg};

    always_comb
    begin
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        ga_next   = ga_reg;
        gb_next   = gb_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;

        if (cmd.load)
        begin
            opa_next  = first_value[W-1:0];
            opb_next  = second_value[W-1:0];
            ga_next   = first_value[W-1:0];
            gb_next   = second_value[W-1:0];
            k_next    = '0;
            g_next    = first_value[W-1:0] | second_value[W-1:0];
            prod_next = '0;
        end

        if (cmd.gcd_step)
        begin
            priority if (!ga_reg[0] && !gb_reg[0])
            begin
                ga_next = ga_reg >> 1;
                gb_next = gb_reg >> 1;
                k_next  = k_reg + CW'(1);
            end
            else if (!ga_reg[0])
                ga_next = ga_reg >> 1;
            else if (!gb_reg[0])
                gb_next = gb_reg >> 1;
            else if (ga_reg >= gb_reg)
                ga_next = ga_reg - gb_reg;
            else
                gb_next = gb_reg - ga_reg;
        end

        // one of ga/gb is zero here; the other holds the odd part (whole operand if one was zero)
        if (cmd.div_init)
        begin
            g_next   = (ga_reg | gb_reg) << k_reg;
            rem_next = '0;
            quo_next = opa_reg;
            cnt_next = CW'(W - 1);
        end

        if (cmd.div_step)
        begin
            if (!div_diff[W])
            begin
                rem_next = div_diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = div_shift[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
        end

        if (cmd.mul_init)
        begin
            prod_next = {{W{1'b0}}, opb_reg};
            cnt_next  = CW'(W - 1);
        end

        if (cmd.mul_step)
        begin
            if (prod_reg[0])
                prod_next = {mul_sum, prod_reg[W-1:1]};
            else
                prod_next = {1'b0, prod_reg[2*W-1:1]};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
    end

    assign status.gcd_done     = (ga_reg == '0) || (gb_reg == '0);
    assign status.zero_operand = (opa_reg == '0) || (opb_reg == '0);
    assign status.count_last   = (cnt_reg == '0);

    assign common_multiple = lfg_pkg::RESULT_WIDTH'(prod_reg);
    assign common_divisor  = lfg_pkg::FIELD_WIDTH'(g_reg);

endmodule

`default_nettype wire

// ----- hdl/lfg_controller.sv -----
// ---------------------------------------------------------------------------
// lfg_controller - sequencer for the LCM/GCD datapath
// Walks GCD, divide and multiply phases (GCD only if an operand is zero) and raises done for one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lfg_controller (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire lfg_pkg::lfg_status_t  status,
    output lfg_pkg::lfg_cmd_t          cmd,
    output logic                       busy,
    output logic                       done
);

    lfg_pkg::lfg_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfg_pkg::ST_IDLE:
                if (start)
                    state_next = lfg_pkg::ST_GCD;
            lfg_pkg::ST_GCD:
                if (status.gcd_done)
                    state_next = status.zero_operand ? lfg_pkg::ST_DONE
                                                     : lfg_pkg::ST_DIV;
            lfg_pkg::ST_DIV:
                if (status.count_last)
                    state_next = lfg_pkg::ST_MUL_INIT;
            lfg_pkg::ST_MUL_INIT:
                state_next = lfg_pkg::ST_MUL;
            lfg_pkg::ST_MUL:
                if (status.count_last)
                    state_next = lfg_pkg::ST_DONE;
            lfg_pkg::ST_DONE:
                state_next = lfg_pkg::ST_IDLE;
            default:
                state_next = lfg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            lfg_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            lfg_pkg::ST_GCD:
            begin
                // g is latched in div_init, also needed for a zero operand
                cmd.gcd_step = !status.gcd_done;
                cmd.div_init = status.gcd_done;
            end
            lfg_pkg::ST_DIV:
                cmd.div_step = 1'b1;
            lfg_pkg::ST_MUL_INIT:
                cmd.mul_init = 1'b1;
            lfg_pkg::ST_MUL:
                cmd.mul_step = 1'b1;
            lfg_pkg::ST_DONE:
                done = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lfg_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- hdl/lcm_from_gcd.sv -----
// ---------------------------------------------------------------------------
// lcm_from_gcd - greatest common divisor and exact least common multiple
// Command-style block: GCD by binary steps, LCM as (a / gcd) * b.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; only
//   the low OPERAND_WIDTH bits of first_value and second_value are used.
//   busy stays high until the result is shown. done is high for exactly one
//   cycle with common_multiple and common_divisor valid in that cycle; the
//   receiver cannot stall, so the result must be captured then.
// Sequence (request to done):
//   the binary GCD loop, then the divider, then the multiplier, then done;
//   the GCD loop does one subtract or halving per cycle. A zero operand skips
//   the divide and multiply phases.
// Throughput: one request at a time; the next is taken the cycle after done.
//   The GCD loop, the bit-serial divider and the shift-add multiplier each
//   take one cycle per step, in turn; the multiplier follows ST_MUL_INIT.
// Reset: rst_n clears the sequencer to idle; no result is pending after it.
// ---------------------------------------------------------------------------
`default_nettype none

module lcm_from_gcd #(
    parameter int OPERAND_WIDTH = lfg_pkg::OPERAND_WIDTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  wire [lfg_pkg::FIELD_WIDTH-1:0]     first_value,
    input  wire [lfg_pkg::FIELD_WIDTH-1:0]     second_value,
    output logic                               busy,
    output logic                               done,
    output logic [lfg_pkg::RESULT_WIDTH-1:0]   common_multiple,
    output logic [lfg_pkg::FIELD_WIDTH-1:0]    common_divisor
);

    lfg_pkg::lfg_cmd_t    cmd;
    lfg_pkg::lfg_status_t status;

    lfg_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lfg_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .first_value     (first_value),
        .second_value    (second_value),
        .status          (status),
        .common_multiple (common_multiple),
        .common_divisor  (common_divisor)
    );

endmodule

`default_nettype wire

// ----- hdl/lfg_checker.sv -----
// ---------------------------------------------------------------------------
// lfg_checker - port-level checks for lcm_from_gcd
// Watches the request/result sequencing and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module lfg_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                start,
    input wire                                busy,
    input wire                                done,
    input wire [lfg_pkg::RESULT_WIDTH-1:0]    common_multiple,
    input wire [lfg_pkg::FIELD_WIDTH-1:0]     common_divisor
);

    // a taken request keeps the block busy
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but busy not raised");

    // done only while busy, and the block frees up right after
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !busy && !done)
        else $error("done not a single cycle ending the request");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    // zero divisor means both operands zero, so the multiple is zero too
    a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        done && (common_divisor == '0) |-> (common_multiple == '0))
        else $error("nonzero multiple with zero divisor");

endmodule

bind lcm_from_gcd lfg_checker u_lfg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .common_multiple (common_multiple),
    .common_divisor  (common_divisor)
);

`default_nettype wire
